### hdl/ptm_pkg.sv
package ptm_pkg;

  // Event codes carried in s_tuser.
  typedef enum logic [2:0] {
    OP_QUERY         = 3'd0,
    OP_SET_MODE      = 3'd1,
    OP_RUN_NOW       = 3'd2,
    OP_SUSPEND       = 3'd3,
    OP_CHANGE_PERIOD = 3'd4,
    OP_REPORT        = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_NEVER   = 2'd0,
    MODE_ONCE    = 2'd1,
    MODE_REGULAR = 2'd2
  } task_mode_t;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned VAR_W    = 64;
  localparam int unsigned SQ_IN_W  = 32;

endpackage

### hdl/ptm_stat.sv
module ptm_stat #(
  parameter int unsigned MW        = 36,
  parameter bit          IS_SIGNED = 1'b0
) (
  input  logic [MW-1:0]             x_scaled,
  input  logic [MW-1:0]             mean_in,
  input  logic [ptm_pkg::VAR_W-1:0] var_in,
  output logic [MW-1:0]             mean_out,
  output logic [ptm_pkg::VAR_W-1:0] var_out
);
  import ptm_pkg::*;

  localparam int unsigned EW = MW + 1;
  localparam int unsigned AW = EW + 3;
  localparam int unsigned DW = EW + 1;
  localparam int unsigned XW = (DW > SQ_IN_W + 1) ? DW : SQ_IN_W + 1;
  localparam int unsigned BW = VAR_W + 4;

  logic signed [EW-1:0] x_e;
  logic signed [EW-1:0] m_e;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_sh;
  logic signed [EW-1:0] m_new;
  logic signed [DW-1:0] diff;
  logic        [DW-1:0] mag;
  logic        [XW-1:0] mag_x;
  logic [VAR_W-1:0]     sq;
  logic [BW-1:0]        blend;

  always_comb begin
    if (IS_SIGNED) begin
      x_e = $signed({x_scaled[MW-1], x_scaled});
      m_e = $signed({mean_in[MW-1], mean_in});
    end else begin
      x_e = $signed({1'b0, x_scaled});
      m_e = $signed({1'b0, mean_in});
    end
    // 7*mean + x, then a floor divide by 8 as an arithmetic shift.
    acc    = (AW'(m_e) <<< 3) - AW'(m_e) + AW'(x_e);
    acc_sh = acc >>> 3;
    m_new  = acc_sh[EW-1:0];
    mean_out = m_new[MW-1:0];

    diff  = DW'(x_e) - DW'(m_new);
    mag   = diff[DW-1] ? DW'(-diff) : DW'(diff);
    mag_x = XW'(mag);
    if (|mag_x[XW-1:SQ_IN_W]) begin
      sq = '1;
    end else begin
      sq = VAR_W'(mag_x[SQ_IN_W-1:0]) * VAR_W'(mag_x[SQ_IN_W-1:0]);
    end

    // floor((15*var + sq) / 16) never leaves the 64-bit range.
    blend   = (BW'(var_in) << 4) - BW'(var_in) + BW'(sq);
    var_out = blend[BW-1:4];
  end

endmodule

### hdl/periodic_task_timing_monitor.sv
// Timing monitor for one periodic task.
// Requests arrive on the s_ channel: s_tuser carries the event code (query, set
// mode, run now, suspend, change period, execution report), s_tdata the times
// and arguments. Each request produces exactly one result on the m_ channel,
// holding the due flag, the on-time flag and the full schedule and statistics
// state after that request.
// cfg_wen/cfg_wdata write the timing mode: 0 reschedules from the old due time,
// 1 from the reported end time. Write it only while no request is in flight.
// A request is captured in an input register; the whole update runs in one
// combinational pass from there into the state and result registers, so the
// result passes the input register and then the result register, and one
// request is taken every cycle while the receiver does not stall. The one-pass
// update holds a 32x32 square per statistic.
// If the receiver stalls, the result holds and one more request is captured;
// s_tready then drops until the result is taken.
// Synchronous reset clears the schedule, the statistics, the timing mode and
// both registers' valid flags.
module periodic_task_timing_monitor #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wen,
  input  logic cfg_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  // s_tdata from bit 0: now_us, end_us, task_succeeded, mode_value,
  // suspend_delay, new_period, zero fill
  input  logic [((4*TIME_BITS+3+7)/8)*8-1:0] s_tdata,
  // s_tuser: opcode
  input  logic [ptm_pkg::OPCODE_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // m_tdata from bit 0: due, on_time, violation_count, exec_time, exec_avg,
  // exec_var, exec_max, start_delay, lag_avg, lag_var, lag_max,
  // next_due, zero fill
  output logic [((162+7*TIME_BITS+2*FRAC_BITS+7)/8)*8-1:0] m_tdata
);
  import ptm_pkg::*;

  localparam int unsigned T        = TIME_BITS;
  localparam int unsigned MEAN_W   = TIME_BITS + FRAC_BITS;
  localparam int unsigned OUT_BITS = 162 + 7*TIME_BITS + 2*FRAC_BITS;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7)/8)*8;

  // Input register.
  logic                in_full;
  logic [OPCODE_W-1:0] op_q;
  logic [T-1:0]        now_q;
  logic [T-1:0]        end_q;
  logic                ok_q;
  logic [MODE_W-1:0]   mode_q;
  logic [T-1:0]        delay_q;
  logic [T-1:0]        np_q;

  // Result flags; the other result fields are the state registers themselves,
  // which change only when a request moves into the result register.
  logic out_valid;
  logic due;
  logic on_time;
  logic sched_mode;

  task_mode_t           run_state;
  logic [T-1:0]         next_due_time;
  logic [T-1:0]         period;
  logic [COUNT_W-1:0]   violations;
  logic [T-1:0]         last_exec;
  logic [MEAN_W-1:0]    exec_mean;
  logic [VAR_W-1:0]     exec_spread;
  logic [T-1:0]         exec_peak;
  logic [T-1:0]         last_delay;
  logic [MEAN_W-1:0]    delay_mean;
  logic [VAR_W-1:0]     delay_spread;
  logic [T-1:0]         delay_peak;

  task_mode_t           run_state_next;
  logic [T-1:0]         next_due_time_next;
  logic [T-1:0]         period_next;
  logic [COUNT_W-1:0]   violations_next;
  logic [T-1:0]         last_exec_next;
  logic [MEAN_W-1:0]    exec_mean_next;
  logic [VAR_W-1:0]     exec_spread_next;
  logic [T-1:0]         exec_peak_next;
  logic [T-1:0]         last_delay_next;
  logic [MEAN_W-1:0]    delay_mean_next;
  logic [VAR_W-1:0]     delay_spread_next;
  logic [T-1:0]         delay_peak_next;
  logic                 due_next;
  logic                 on_time_next;

  logic                 move;
  logic [T-1:0]         due_base;
  logic [T-1:0]         resched;
  logic [T-1:0]         rep_exec;
  logic [T-1:0]         rep_delay;
  logic [MEAN_W-1:0]    exec_scaled;
  logic signed [MEAN_W-1:0] delay_scaled;
  logic [MEAN_W-1:0]    exec_mean_upd;
  logic [VAR_W-1:0]     exec_spread_upd;
  logic [MEAN_W-1:0]    delay_mean_upd;
  logic [VAR_W-1:0]     delay_spread_upd;

  assign move     = in_full && (!out_valid || m_tready);
  assign s_tready = !in_full || move;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q    <= s_tuser;
      now_q   <= s_tdata[T-1:0];
      end_q   <= s_tdata[2*T-1:T];
      ok_q    <= s_tdata[2*T];
      mode_q  <= s_tdata[2*T+2:2*T+1];
      delay_q <= s_tdata[3*T+2:2*T+3];
      np_q    <= s_tdata[4*T+2:3*T+3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode <= 1'b0;
    end else if (cfg_wen) begin
      sched_mode <= cfg_wdata;
    end
  end

  // Report arithmetic; a zero due time counts as a first run on time.
  assign due_base     = (next_due_time == '0) ? now_q : next_due_time;
  assign rep_delay    = now_q - due_base;
  assign rep_exec     = end_q - now_q;
  assign resched      = ok_q ? ((sched_mode ? end_q : due_base) + period) : due_base;
  assign exec_scaled  = MEAN_W'(rep_exec) << FRAC_BITS;
  assign delay_scaled = MEAN_W'($signed(rep_delay)) <<< FRAC_BITS;

  ptm_stat #(.MW(MEAN_W), .IS_SIGNED(1'b0)) u_exec_stat (
    .x_scaled (exec_scaled),
    .mean_in  (exec_mean),
    .var_in   (exec_spread),
    .mean_out (exec_mean_upd),
    .var_out  (exec_spread_upd)
  );

  ptm_stat #(.MW(MEAN_W), .IS_SIGNED(1'b1)) u_delay_stat (
    .x_scaled (delay_scaled),
    .mean_in  (delay_mean),
    .var_in   (delay_spread),
    .mean_out (delay_mean_upd),
    .var_out  (delay_spread_upd)
  );

  always_comb begin
    run_state_next     = run_state;
    next_due_time_next = next_due_time;
    period_next        = period;
    violations_next    = violations;
    last_exec_next     = last_exec;
    exec_mean_next     = exec_mean;
    exec_spread_next   = exec_spread;
    exec_peak_next     = exec_peak;
    last_delay_next    = last_delay;
    delay_mean_next    = delay_mean;
    delay_spread_next  = delay_spread;
    delay_peak_next    = delay_peak;
    on_time_next       = 1'b1;

    unique case (opcode_t'(op_q))
      OP_SET_MODE: begin
        if (mode_q <= MODE_REGULAR) begin
          run_state_next = task_mode_t'(mode_q);
        end
      end
      OP_RUN_NOW: begin
        if (run_state == MODE_NEVER) begin
          run_state_next = MODE_ONCE;
        end
        next_due_time_next = now_q;
      end
      OP_SUSPEND: begin
        next_due_time_next = now_q + delay_q;
      end
      OP_CHANGE_PERIOD: begin
        period_next        = np_q;
        run_state_next     = MODE_REGULAR;
        next_due_time_next = now_q;
      end
      OP_REPORT: begin
        if (run_state == MODE_ONCE) begin
          run_state_next = MODE_NEVER;
        end
        // A due time that is already behind the start is a violation.
        if (resched < now_q) begin
          violations_next    = violations + COUNT_W'(1);
          next_due_time_next = now_q + period;
          on_time_next       = 1'b0;
        end else begin
          next_due_time_next = resched;
        end
        last_exec_next    = rep_exec;
        exec_mean_next    = exec_mean_upd;
        exec_spread_next  = exec_spread_upd;
        if (rep_exec > exec_peak) begin
          exec_peak_next = rep_exec;
        end
        last_delay_next   = rep_delay;
        delay_mean_next   = delay_mean_upd;
        delay_spread_next = delay_spread_upd;
        if ($signed(rep_delay) > $signed(delay_peak)) begin
          delay_peak_next = rep_delay;
        end
      end
      default: begin
      end
    endcase

    due_next = (run_state_next != MODE_NEVER) && (now_q >= next_due_time_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      due           <= 1'b0;
      on_time       <= 1'b1;
      run_state     <= MODE_NEVER;
      next_due_time <= '0;
      period        <= '0;
      violations    <= '0;
      last_exec     <= '0;
      exec_mean     <= '0;
      exec_spread   <= '0;
      exec_peak     <= '0;
      last_delay    <= '0;
      delay_mean    <= '0;
      delay_spread  <= '0;
      delay_peak    <= '0;
    end else begin
      if (move) begin
        out_valid     <= 1'b1;
        due           <= due_next;
        on_time       <= on_time_next;
        run_state     <= run_state_next;
        next_due_time <= next_due_time_next;
        period        <= period_next;
        violations    <= violations_next;
        last_exec     <= last_exec_next;
        exec_mean     <= exec_mean_next;
        exec_spread   <= exec_spread_next;
        exec_peak     <= exec_peak_next;
        last_delay    <= last_delay_next;
        delay_mean    <= delay_mean_next;
        delay_spread  <= delay_spread_next;
        delay_peak    <= delay_peak_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tdata = OUT_W'({next_due_time, delay_peak, delay_spread, delay_mean,
                           last_delay, exec_peak, exec_spread, exec_mean,
                           last_exec, violations, on_time, due});

endmodule

### tb/sv/ptm_result_check.sv
// Watches both stream channels of the timing monitor, predicts the result of
// every accepted request from its own copy of the schedule and statistics, and
// compares each returned result field by field with the oldest prediction.
module ptm_result_check #(
  parameter int IN_W  = 136,
  parameter int OUT_W = 400
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic             cfg_wdata,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic [2:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               failures,
  output int               pending
);
  import ptm_pkg::*;

  localparam int FRAC_BITS    = 4;
  localparam int MEAN_SHIFT   = 3;
  localparam int SPREAD_SHIFT = 4;

  // Request fields, declared from the top bit down.
  typedef struct packed {
    logic [4:0]  fill;
    logic [31:0] new_period;
    logic [31:0] suspend_delay;
    logic [1:0]  mode_value;
    logic        task_succeeded;
    logic [31:0] end_us;
    logic [31:0] now_us;
  } event_word_t;

  // Result fields, declared from the top bit down.
  typedef struct packed {
    logic [5:0]  fill;
    logic [31:0] next_due;
    logic [31:0] lag_max;
    logic [63:0] lag_var;
    logic [35:0] lag_avg;
    logic [31:0] start_delay;
    logic [31:0] exec_max;
    logic [63:0] exec_var;
    logic [35:0] exec_avg;
    logic [31:0] exec_time;
    logic [31:0] violation_count;
    logic        on_time;
    logic        due;
  } status_word_t;

  status_word_t expected_status[$];
  int fail_count = 0;
  int outstanding = 0;
  int result_index = 0;

  logic               sched_mode;
  task_mode_t         run_state;
  logic [31:0]        due_time;
  logic [31:0]        period;
  logic [31:0]        violations;
  logic [31:0]        last_exec;
  logic [35:0]        exec_mean;
  logic [63:0]        exec_spread;
  logic [31:0]        exec_peak;
  logic [31:0]        last_delay;
  logic signed [63:0] delay_mean;
  logic [63:0]        delay_spread;
  logic [31:0]        delay_peak;

  assign failures = fail_count;
  assign pending  = outstanding;

  task automatic report_mismatch(input string what);
    $display("[%0t] result %0d: %s", $realtime, result_index, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  function automatic logic [63:0] square_sat(input logic signed [63:0] d);
    logic [63:0] mag;
    mag = d[63] ? 64'(-d) : 64'(d);
    if (mag[63:32] != '0) return '1;
    return 64'(mag[31:0]) * 64'(mag[31:0]);
  endfunction

  // Moves the spread one sixteenth of the way toward the new square, rounding
  // toward minus infinity in both directions.
  function automatic logic [63:0] blend_spread(input logic [63:0] v, input logic [63:0] s);
    logic [64:0] down;
    if (s >= v) return v + ((s - v) >> SPREAD_SHIFT);
    down = 65'(v - s) + ((65'd1 << SPREAD_SHIFT) - 65'd1);
    return v - 64'(down >> SPREAD_SHIFT);
  endfunction

  task automatic clear_schedule();
    sched_mode   = 1'b0;
    run_state    = MODE_NEVER;
    due_time     = '0;
    period       = '0;
    violations   = '0;
    last_exec    = '0;
    exec_mean    = '0;
    exec_spread  = '0;
    exec_peak    = '0;
    last_delay   = '0;
    delay_mean   = '0;
    delay_spread = '0;
    delay_peak   = '0;
  endtask

  task automatic advance_monitor(input logic [2:0] op, input event_word_t ev,
                                 output status_word_t res);
    logic [63:0]        mean_sum;
    logic signed [63:0] scaled;
    logic signed [63:0] gap;
    logic               late;
    late = 1'b0;
    case (op)
      OP_SET_MODE: begin
        if (ev.mode_value <= MODE_REGULAR) run_state = task_mode_t'(ev.mode_value);
      end
      OP_RUN_NOW: begin
        if (run_state == MODE_NEVER) run_state = MODE_ONCE;
        due_time = ev.now_us;
      end
      OP_SUSPEND: due_time = ev.now_us + ev.suspend_delay;
      OP_CHANGE_PERIOD: begin
        period    = ev.new_period;
        run_state = MODE_REGULAR;
        due_time  = ev.now_us;
      end
      OP_REPORT: begin
        // The very first run counts as exactly on time.
        if (due_time == '0) due_time = ev.now_us;
        last_delay = ev.now_us - due_time;
        if (ev.task_succeeded)
          due_time = (sched_mode ? ev.end_us : due_time) + period;
        if (run_state == MODE_ONCE) run_state = MODE_NEVER;
        // A due time left behind the start is a real-time violation.
        if (due_time < ev.now_us) begin
          violations = violations + 32'd1;
          due_time   = ev.now_us + period;
          late       = 1'b1;
        end
        last_exec = ev.end_us - ev.now_us;
        mean_sum  = 64'(exec_mean) * 7 + (64'(last_exec) << FRAC_BITS);
        exec_mean = mean_sum[MEAN_SHIFT +: 36];
        scaled    = $signed(64'(last_exec) << FRAC_BITS);
        gap       = scaled - $signed(64'(exec_mean));
        exec_spread = blend_spread(exec_spread, square_sat(gap));
        if (last_exec > exec_peak) exec_peak = last_exec;

        scaled       = 64'($signed(last_delay));
        scaled       = scaled <<< FRAC_BITS;
        delay_mean   = (delay_mean * 7 + scaled) >>> MEAN_SHIFT;
        gap          = scaled - delay_mean;
        delay_spread = blend_spread(delay_spread, square_sat(gap));
        if ($signed(last_delay) > $signed(delay_peak)) delay_peak = last_delay;
      end
      default: ;
    endcase

    res                 = '0;
    res.due             = (run_state != MODE_NEVER) && (ev.now_us >= due_time);
    res.on_time         = !late;
    res.violation_count = violations;
    res.exec_time       = last_exec;
    res.exec_avg        = exec_mean;
    res.exec_var        = exec_spread;
    res.exec_max        = exec_peak;
    res.start_delay     = last_delay;
    res.lag_avg         = delay_mean[35:0];
    res.lag_var         = delay_spread;
    res.lag_max         = delay_peak;
    res.next_due        = due_time;
  endtask

  always @(posedge clk) begin
    event_word_t  ev;
    status_word_t got;
    status_word_t want;
    if (rst) begin
      clear_schedule();
      expected_status.delete();
    end else begin
      if (cfg_wen) sched_mode = cfg_wdata;
      // Results pass the input and result registers after their requests, so the compare goes
      // first and a request accepted on this edge cannot be matched yet.
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_status.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = expected_status.pop_front();
          check_field("due", 64'(got.due), 64'(want.due));
          check_field("on_time", 64'(got.on_time), 64'(want.on_time));
          check_field("violation_count", 64'(got.violation_count),
                      64'(want.violation_count));
          check_field("exec_time", 64'(got.exec_time), 64'(want.exec_time));
          check_field("exec_avg", 64'(got.exec_avg), 64'(want.exec_avg));
          check_field("exec_var", got.exec_var, want.exec_var);
          check_field("exec_max", 64'(got.exec_max), 64'(want.exec_max));
          check_field("start_delay", 64'(got.start_delay), 64'(want.start_delay));
          check_field("lag_avg", 64'(got.lag_avg), 64'(want.lag_avg));
          check_field("lag_var", got.lag_var, want.lag_var);
          check_field("lag_max", 64'(got.lag_max), 64'(want.lag_max));
          check_field("next_due", 64'(got.next_due), 64'(want.next_due));
        end
        result_index++;
      end
      if (s_tvalid && s_tready) begin
        ev = s_tdata;
        advance_monitor(s_tuser, ev, want);
        expected_status.push_back(want);
      end
    end
    outstanding <= expected_status.size();
  end

endmodule

### tb/sv/periodic_task_timing_monitor_tb.sv
module periodic_task_timing_monitor_tb;
  import ptm_pkg::*;

  localparam int IN_W  = 136;
  localparam int OUT_W = 400;

  // Event codes and a mode value that the block must treat as no-ops.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] MODE_BAD    = 2'd3;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_style_t;

  logic             clk;
  logic             rst       = 1'b1;
  logic             cfg_wen   = 1'b0;
  logic             cfg_wdata = 1'b0;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata   = '0;
  logic [2:0]       s_tuser   = '0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  int               failures;
  int               pending;

  int           burst_left  = 0;
  stall_style_t ready_style = STALL_NONE;
  int           ready_left  = 0;
  logic         mode_shadow = 1'b0;
  logic [31:0]  clock_us    = '0;
  logic [31:0]  due_guess   = '0;
  logic [31:0]  period_guess = 32'd1000;

  periodic_task_timing_monitor DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  ptm_result_check #(.IN_W(IN_W), .OUT_W(OUT_W)) result_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("periodic_task_timing_monitor verification failed");
    $finish;
  end

  // The receiver switches to a randomly chosen stall pattern whenever the current one runs out.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_style = stall_style_t'($urandom_range(0, 3));
      ready_left  = $urandom_range(10, 150);
    end
    ready_left--;
    case (ready_style)
      STALL_NONE:  m_tready <= 1'b1;
      STALL_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
      STALL_HALF:  m_tready <= 1'($urandom_range(0, 1));
      default:     m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_event(input logic [2:0] op, input logic [31:0] now_t,
                            input logic [31:0] end_t, input logic ok,
                            input logic [1:0] mode_v, input logic [31:0] delay_v,
                            input logic [31:0] period_v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_W - 131){1'b0}}, period_v, delay_v, mode_v, ok, end_t, now_t};
    do @(posedge clk); while (!s_tready);
  endtask

  // Holds off the sender until every request has produced its result.
  task automatic drain_requests();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic set_sched_mode(input logic value);
    drain_requests();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    mode_shadow = value;
  endtask

  // Mostly plausible task activity around a tracked schedule, with a share of
  // fully random requests mixed in.
  task automatic random_event();
    int          pick;
    logic [31:0] start_t;
    logic [31:0] end_t;
    logic [31:0] delay_v;
    logic        ok;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_event(3'($urandom_range(0, 7)), $urandom, $urandom, 1'($urandom_range(0, 1)),
                 2'($urandom_range(0, 3)), $urandom, $urandom);
    end else if (pick < 22) begin
      case ($urandom_range(0, 3))
        0: clock_us = $urandom;
        1: clock_us = 32'hFFFF_F000 + $urandom_range(0, 4095);
        default: clock_us = clock_us + $urandom_range(0, 10000);
      endcase
      period_guess = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 3000);
      due_guess = clock_us;
      send_event(OP_CHANGE_PERIOD, clock_us, $urandom, 1'b0, MODE_NEVER, $urandom,
                 period_guess);
    end else if (pick < 27) begin
      case ($urandom_range(0, 5))
        0: send_event(OP_SET_MODE, clock_us, '0, 1'b0, MODE_NEVER, '0, '0);
        1: send_event(OP_SET_MODE, clock_us, '0, 1'b0, MODE_ONCE, '0, '0);
        2: send_event(OP_SET_MODE, clock_us, '0, 1'b0, MODE_BAD, '0, '0);
        default: send_event(OP_SET_MODE, clock_us, '0, 1'b0, MODE_REGULAR, '0, '0);
      endcase
    end else if (pick < 31) begin
      due_guess = clock_us;
      send_event(OP_RUN_NOW, clock_us, '0, 1'b0, MODE_NEVER, '0, '0);
    end else if (pick < 35) begin
      delay_v = $urandom_range(0, 3000);
      due_guess = clock_us + delay_v;
      send_event(OP_SUSPEND, clock_us, '0, 1'b0, MODE_NEVER, delay_v, '0);
    end else if (pick < 48) begin
      clock_us = clock_us + $urandom_range(0, 2000) - 1000;
      send_event(OP_QUERY, clock_us, '0, 1'b0, MODE_NEVER, '0, '0);
    end else begin
      if ($urandom_range(0, 19) == 0) start_t = due_guess + $urandom_range(0, 100000);
      else start_t = due_guess + $urandom_range(0, 600) - 150;
      if ($urandom_range(0, 19) == 0) end_t = start_t + $urandom;
      else end_t = start_t + $urandom_range(0, 2000);
      ok = ($urandom_range(0, 9) != 0);
      send_event(OP_REPORT, start_t, end_t, ok, MODE_NEVER, '0, '0);
      clock_us = end_t;
      if (ok) due_guess = (mode_shadow ? end_t : due_guess) + period_guess;
      if (due_guess < start_t) due_guess = start_t + period_guess;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_sched_mode(1'b0);
    send_event(OP_QUERY, '0, '0, 1'b0, MODE_NEVER, '0, '0);
    send_event(OP_QUERY, '1, '1, 1'b1, MODE_BAD, '1, '1);
    // First report with no due time set yet.
    send_event(OP_REPORT, 32'd100, 32'd130, 1'b1, MODE_NEVER, '0, '0);
    send_event(OP_SET_MODE, 32'd100, '0, 1'b0, MODE_ONCE, '0, '0);
    // End before start: the execution time wraps and the squared deviation saturates.
    send_event(OP_REPORT, 32'd100, 32'd90, 1'b1, MODE_NEVER, '0, '0);
    send_event(OP_SET_MODE, 32'd150, '0, 1'b0, MODE_BAD, '0, '0);
    send_event(OP_SPARE_LO, 32'd200, '0, 1'b0, MODE_NEVER, '0, '0);
    send_event(OP_SPARE_HI, 32'd200, '1, 1'b1, MODE_REGULAR, '1, '1);
    send_event(OP_CHANGE_PERIOD, 32'd1000, '0, 1'b0, MODE_NEVER, '0, 32'd500);
    send_event(OP_RUN_NOW, 32'd1200, '0, 1'b0, MODE_NEVER, '0, '0);
    send_event(OP_SET_MODE, 32'd1250, '0, 1'b0, MODE_NEVER, '0, '0);
    send_event(OP_RUN_NOW, 32'd1300, '0, 1'b0, MODE_NEVER, '0, '0);
    send_event(OP_SUSPEND, 32'hFFFF_FFF0, '0, 1'b0, MODE_NEVER, 32'h20, '0);
    send_event(OP_SUSPEND, 32'd5, '0, 1'b0, MODE_NEVER, '1, '0);
    send_event(OP_CHANGE_PERIOD, 32'h1000, '0, 1'b0, MODE_NEVER, '0, '1);
    // Failed run left behind its due time: a violation.
    send_event(OP_REPORT, 32'h1400, 32'h1500, 1'b0, MODE_NEVER, '0, '0);
    // Start delays at both ends of the signed range.
    send_event(OP_CHANGE_PERIOD, 32'h8000_0000, '0, 1'b0, MODE_NEVER, '0, 32'd100);
    send_event(OP_REPORT, '0, 32'd10, 1'b1, MODE_NEVER, '0, '0);
    send_event(OP_CHANGE_PERIOD, 32'd1, '0, 1'b0, MODE_NEVER, '0, 32'd100);
    send_event(OP_REPORT, 32'h8000_0000, 32'h8000_0010, 1'b1, MODE_NEVER, '0, '0);
    send_event(OP_REPORT, '0, '1, 1'b0, MODE_NEVER, '0, '0);

    set_sched_mode(1'b1);
    send_event(OP_CHANGE_PERIOD, 32'd5000, '0, 1'b0, MODE_NEVER, '0, 32'd1000);
    send_event(OP_REPORT, 32'd5010, 32'd5400, 1'b1, MODE_NEVER, '0, '0);
    send_event(OP_REPORT, 32'd9500, 32'd8000, 1'b1, MODE_NEVER, '0, '0);
    send_event(OP_SET_MODE, 32'd9600, '0, 1'b0, MODE_ONCE, '0, '0);
    send_event(OP_QUERY, '1, '0, 1'b0, MODE_NEVER, '0, '0);

    for (int phase = 0; phase < 6; phase++) begin
      set_sched_mode(1'($urandom_range(0, 1)));
      repeat (235) random_event();
    end

    drain_requests();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("periodic_task_timing_monitor verification clean");
    end else begin
      $display("periodic_task_timing_monitor verification failed");
    end
    $finish;
  end

endmodule
